FILE: design/assert_macros.svh
// Assertion helpers included by sliding_median_spike_detector.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  `ASSERT_CLK(label, !(cond), msg)

`endif

FILE: design/smsd_pkg.sv
package smsd_pkg;

  // Width of the saturating spike counter.
  localparam int COUNT_W = 32;

  // Per-cycle command from the controller to every window cell.
  typedef struct packed {
    logic update;  // load next value and age
    logic full;    // window held window_length entries: evict the oldest
  } cell_ctl_t;

endpackage

FILE: design/smsd_cell.sv
module smsd_cell #(
  parameter int VAL_W = 16,
  parameter int AGE_W = 8,
  parameter int LEN_W = 9,
  parameter int IDX   = 0
) (
  input  logic                 clk,
  input  smsd_pkg::cell_ctl_t  ctl,
  input  logic [LEN_W-1:0]     fill,       // entries held before the request
  input  logic [LEN_W-1:0]     fill_post,  // entries held after eviction
  input  logic [AGE_W-1:0]     len_m1,     // age of the entry to drop
  input  logic [VAL_W-1:0]     sample,
  input  logic [VAL_W-1:0]     ev_val,     // value of the entry being dropped
  input  logic [VAL_W-1:0]     right_val,
  input  logic [AGE_W-1:0]     right_age,
  input  logic [VAL_W-1:0]     left_wval,
  input  logic [AGE_W-1:0]     left_wage,
  input  logic                 left_g,
  output logic [VAL_W-1:0]     val,
  output logic [AGE_W-1:0]     age,
  output logic                 ev,
  output logic [VAL_W-1:0]     wval,
  output logic [AGE_W-1:0]     wage,
  output logic                 g
);
  import smsd_pkg::*;

  logic [VAL_W-1:0] val_r, val_nxt;
  logic [AGE_W-1:0] age_r, age_nxt;
  logic             vld, wvld, after_ev, take_right;

  assign vld = fill > LEN_W'(IDX);
  assign ev  = vld && (age_r == len_m1);

  // Order is (value up, age down), so everything at or above the dropped
  // value, except the dropped entry itself, sits to its right.
  assign after_ev   = vld && !ev && (val_r >= ev_val);
  assign take_right = ctl.full && (ev || after_ev);

  assign wval = take_right ? right_val : val_r;
  assign wage = take_right ? right_age : age_r;
  assign wvld = fill_post > LEN_W'(IDX);

  // True from the insertion point on.
  assign g = !wvld || (wval > sample);

  always_comb begin
    if (!g) begin
      val_nxt = wval;
      age_nxt = wage + AGE_W'(1);
    end else if (left_g) begin
      val_nxt = left_wval;
      age_nxt = left_wage + AGE_W'(1);
    end else begin
      val_nxt = sample;
      age_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.update) begin
      val_r <= val_nxt;
      age_r <= age_nxt;
    end
  end

  assign val = val_r;
  assign age = age_r;

endmodule

FILE: design/sliding_median_spike_detector.sv
// Sliding-window median spike detector.
// Input stream in_*: one unsigned sample per request in in_tdata.
// Output stream out_*: one result per sample: window_full, twice the median
// of the window before the sample, the spike flag and the saturating spike
// count. A sample is a spike when the window is full and sample >= twice_median.
// Config: cfg_wen/cfg_wdata writes window_length (clamped to 2..WINDOW_MAX)
// and empties the window; the spike count is kept. Write only while idle.
// Flow: an accepted sample moves from idle to the scan state, which reduces
// the row to the dropped value and the middle entries, and then to the
// update state, where the WINDOW_MAX cells of the row drop the oldest
// entry and insert the new one in a single update, and the result is registered
// once the output slot is free. A new sample is accepted in idle only.
// Reset: window length 2, window empty, count zero, no result pending.
// Stall: a finished result waits in the output register; the next sample is
// still accepted and is held before its row update until the slot frees.
`include "assert_macros.svh"

module sliding_median_spike_detector #(
  parameter int WINDOW_MAX  = 256,
  parameter int SAMPLE_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]   in_tdata,   // [SAMPLE_BITS-1:0] sample
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // from bit 0: window_full, twice_median, notify, notify_count
  output logic [((SAMPLE_BITS+42)/8)*8-1:0]  out_tdata,
  input  logic                               cfg_wen,
  input  logic [$clog2(WINDOW_MAX+1)-1:0]    cfg_wdata   // window_length
);
  import smsd_pkg::*;

  localparam int LEN_W  = $clog2(WINDOW_MAX + 1);
  localparam int AGE_W  = $clog2(WINDOW_MAX);
  localparam int TW_W   = SAMPLE_BITS + 1;
  localparam int OUT_W  = 1 + TW_W + 1 + COUNT_W;
  localparam int OUT_TW = ((OUT_W + 7) / 8) * 8;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_UPD  = 2'd2;

  logic [1:0]             state_r, state_nxt;
  logic [SAMPLE_BITS-1:0] sample_r;
  logic [LEN_W-1:0]       len_r, len_nxt, fill_r, fill_nxt, fill_post;
  logic [SAMPLE_BITS-1:0] ev_val_r, med_a_r, med_b_r;
  logic [SAMPLE_BITS-1:0] ev_or, med_a, med_b;
  logic                   full_r;
  logic [COUNT_W-1:0]     count_r, count_nxt;
  logic                   out_tvalid_r, out_full_r, out_notify_r;
  logic [TW_W-1:0]        out_twice_r, twice;
  logic                   notify, in_acc, slot_free, upd_go;
  logic [AGE_W-1:0]       half, half_m1, len_m1;
  cell_ctl_t              ctl;

  logic [SAMPLE_BITS-1:0] cell_val  [WINDOW_MAX];
  logic [AGE_W-1:0]       cell_age  [WINDOW_MAX];
  logic [SAMPLE_BITS-1:0] cell_wval [WINDOW_MAX];
  logic [AGE_W-1:0]       cell_wage [WINDOW_MAX];
  logic [WINDOW_MAX-1:0]  cell_ev, cell_g;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign slot_free = !out_tvalid_r || out_tready;
  assign upd_go    = (state_r == S_UPD) && slot_free;

  assign half    = AGE_W'(len_r >> 1);
  assign half_m1 = half - AGE_W'(1);
  assign len_m1  = AGE_W'(len_r - LEN_W'(1));

  assign ctl.update = upd_go;
  assign ctl.full   = full_r;
  assign fill_post  = fill_r - LEN_W'(full_r);

  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    logic [SAMPLE_BITS-1:0] rv, lwv;
    logic [AGE_W-1:0]       ra, lwa;
    logic                   lg;

    if (i == WINDOW_MAX - 1) begin : g_last
      assign rv = '0;
      assign ra = '0;
    end else begin : g_mid
      assign rv = cell_val[i+1];
      assign ra = cell_age[i+1];
    end

    if (i == 0) begin : g_first
      assign lwv = '0;
      assign lwa = '0;
      assign lg  = 1'b0;
    end else begin : g_left
      assign lwv = cell_wval[i-1];
      assign lwa = cell_wage[i-1];
      assign lg  = cell_g[i-1];
    end

    smsd_cell #(
      .VAL_W (SAMPLE_BITS),
      .AGE_W (AGE_W),
      .LEN_W (LEN_W),
      .IDX   (i)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .fill      (fill_r),
      .fill_post (fill_post),
      .len_m1    (len_m1),
      .sample    (sample_r),
      .ev_val    (ev_val_r),
      .right_val (rv),
      .right_age (ra),
      .left_wval (lwv),
      .left_wage (lwa),
      .left_g    (lg),
      .val       (cell_val[i]),
      .age       (cell_age[i]),
      .ev        (cell_ev[i]),
      .wval      (cell_wval[i]),
      .wage      (cell_wage[i]),
      .g         (cell_g[i])
    );
  end

  // Reduce the row to the dropped value and the two middle entries.
  always_comb begin
    ev_or = '0;
    med_a = '0;
    med_b = '0;
    for (int i = 0; i < WINDOW_MAX; i++) begin
      if (cell_ev[i]) ev_or = ev_or | cell_val[i];
      if (AGE_W'(i) == half) med_a = med_a | cell_val[i];
      if (AGE_W'(i) == half_m1) med_b = med_b | cell_val[i];
    end
  end

  always_comb begin
    if (!full_r) begin
      twice = '0;
    end else if (len_r[0]) begin
      twice = {med_a_r, 1'b0};
    end else begin
      twice = {1'b0, med_a_r} + {1'b0, med_b_r};
    end
    notify    = full_r && ({1'b0, sample_r} >= twice);
    count_nxt = count_r;
    if (notify && (count_r != {COUNT_W{1'b1}})) count_nxt = count_r + COUNT_W'(1);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_acc) state_nxt = S_SCAN;
      S_SCAN: state_nxt = S_UPD;
      S_UPD:  if (slot_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    len_nxt  = len_r;
    fill_nxt = fill_r;
    if (cfg_wen) begin
      if (cfg_wdata < LEN_W'(2)) begin
        len_nxt = LEN_W'(2);
      end else if (cfg_wdata > LEN_W'(WINDOW_MAX)) begin
        len_nxt = LEN_W'(WINDOW_MAX);
      end else begin
        len_nxt = cfg_wdata;
      end
      fill_nxt = '0;
    end else if (upd_go && !full_r) begin
      fill_nxt = fill_r + LEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      len_r        <= LEN_W'(2);
      fill_r       <= '0;
      count_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      len_r   <= len_nxt;
      fill_r  <= fill_nxt;
      if (upd_go) begin
        count_r      <= count_nxt;
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) sample_r <= in_tdata[SAMPLE_BITS-1:0];
    if (state_r == S_SCAN) begin
      ev_val_r <= ev_or;
      med_a_r  <= med_a;
      med_b_r  <= med_b;
      full_r   <= (fill_r == len_r);
    end
    if (upd_go) begin
      out_full_r   <= full_r;
      out_twice_r  <= twice;
      out_notify_r <= notify;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = OUT_TW'({count_r, out_notify_r, out_twice_r, out_full_r});

  `ASSERT_NEVER(a_fill_le_len, fill_r > len_r, "fill level exceeds window length")
  `ASSERT_CLK(a_one_evict, (state_r == S_SCAN) && (fill_r == len_r) |-> $onehot(cell_ev),
              "full window must have exactly one oldest entry")
  `ASSERT_CLK(a_count_mono, 1'b1 |=> count_r >= $past(count_r),
              "spike count decreased")
  `ASSERT_CLK(a_notify_full, out_tvalid_r && out_notify_r |-> out_full_r,
              "spike flagged on a window that was not full")
  `ASSERT_CLK(a_upd_loads, upd_go |=> out_tvalid_r && (state_r == S_IDLE),
              "row update did not produce a result")

endmodule

FILE: test/tb_sliding_median_spike_detector.sv
`timescale 1ns / 1ps

module tb_sliding_median_spike_detector;
  import smsd_pkg::*;

  localparam int WIN_MAX    = 256;
  localparam int CYCLE_CAP  = 400000;

  typedef struct packed {
    logic [COUNT_W-1:0] notify_count;
    logic               notify;
    logic [16:0]        twice_median;
    logic               window_full;
  } median_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;
  logic        cfg_wen = 1'b0;
  logic [8:0]  cfg_wdata = '0;

  // predictor state: window in ascending order plus arrival order for eviction
  logic [15:0]        sorted_vals [0:WIN_MAX-1];
  logic [15:0]        arrival_q [$];
  int                 held;
  int                 win_len;
  logic [COUNT_W-1:0] spike_total;
  logic [15:0]        last_sample;

  median_result_t pending_results [$];
  int             fail_count = 0;
  int             cycle_count = 0;
  int             send_idle_pct;
  int             recv_stall_pct;

  sliding_median_spike_detector dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata)
  );

  always #2 clk = ~clk;

  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("tb_sliding_median_spike_detector NOT OK");
      $finish;
    end
  end

  function automatic median_result_t step_window(input logic [15:0] s);
    median_result_t r;
    logic [15:0] oldest;
    int e;
    int p;
    int i;
    r = '0;
    if (held == win_len) begin
      r.window_full = 1'b1;
      if (win_len % 2 == 1)
        r.twice_median = {sorted_vals[win_len / 2], 1'b0};
      else
        r.twice_median = {1'b0, sorted_vals[win_len / 2 - 1]} + {1'b0, sorted_vals[win_len / 2]};
      if ({1'b0, s} >= r.twice_median) begin
        r.notify = 1'b1;
        if (spike_total != '1)
          spike_total = spike_total + 1;
      end
      // drop the oldest sample; any equal entry will do
      oldest = arrival_q.pop_front();
      e = 0;
      while (sorted_vals[e] != oldest)
        e++;
      for (i = e; i + 1 < held; i++)
        sorted_vals[i] = sorted_vals[i + 1];
      held--;
    end
    p = 0;
    while (p < held && sorted_vals[p] <= s)
      p++;
    for (i = held; i > p; i--)
      sorted_vals[i] = sorted_vals[i - 1];
    sorted_vals[p] = s;
    held++;
    arrival_q.push_back(s);
    r.notify_count = spike_total;
    return r;
  endfunction

  function automatic logic [15:0] next_sample();
    int pick;
    logic [15:0] s;
    pick = $urandom_range(0, 99);
    if (pick < 45)
      s = 16'($urandom_range(100, 300));
    else if (pick < 60)
      s = 16'($urandom_range(400, 65535));
    else if (pick < 72)
      s = last_sample;
    else if (pick < 86)
      s = 16'($urandom_range(0, 65535));
    else if (pick < 93)
      s = 16'd0;
    else
      s = 16'hFFFF;
    last_sample = s;
    return s;
  endfunction

  always @(posedge clk) begin : check_results
    median_result_t want;
    median_result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[50:0];
      if (pending_results.size() == 0) begin
        $display("%0t: result without pending sample: actual %h", $realtime, got);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.window_full !== want.window_full) begin
          $display("%0t: window_full expected %0d actual %0d",
                   $realtime, want.window_full, got.window_full);
          fail_count++;
        end
        if (got.twice_median !== want.twice_median) begin
          $display("%0t: twice_median expected %0d actual %0d",
                   $realtime, want.twice_median, got.twice_median);
          fail_count++;
        end
        if (got.notify !== want.notify) begin
          $display("%0t: notify expected %0d actual %0d", $realtime, want.notify, got.notify);
          fail_count++;
        end
        if (got.notify_count !== want.notify_count) begin
          $display("%0t: notify_count expected %0d actual %0d",
                   $realtime, want.notify_count, got.notify_count);
          fail_count++;
        end
      end
    end
  end

  task automatic set_pacing(input int idle_pct, input int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
  endtask

  task automatic send_sample(input logic [15:0] s);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= s;
    do
      @(posedge clk);
    while (!in_tready);
    pending_results.push_back(step_window(s));
  endtask

  // lower the request and let every result drain
  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_length(input logic [8:0] value);
    wait_drained();
    @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_wen <= 1'b0;
    if (value < 2)
      win_len = 2;
    else if (value > WIN_MAX)
      win_len = WIN_MAX;
    else
      win_len = value;
    held = 0;
    arrival_q.delete();
  endtask

  task automatic test_directed_edges();
    set_pacing(0, 0);
    // reset length of two: zero median flags everything, full scale does not
    send_sample(16'd0);
    send_sample(16'd0);
    send_sample(16'd0);
    send_sample(16'hFFFF);
    send_sample(16'hFFFF);
    send_sample(16'hFFFF);
    send_sample(16'd0);
    // odd length with equal values, spike exactly at twice the median
    write_length(9'd3);
    send_sample(16'd5);
    send_sample(16'd5);
    send_sample(16'd5);
    send_sample(16'd10);
    send_sample(16'd9);
    // rewrite with a full window, then clamp from below
    send_sample(16'd7);
    write_length(9'd1);
    send_sample(16'd1);
    send_sample(16'd2);
    send_sample(16'd3);
    write_length(9'd0);
    send_sample(16'h8000);
    send_sample(16'h7FFF);
    send_sample(16'hFFFF);
    // clamp from above
    write_length(9'h1FF);
    send_sample(16'd4);
  endtask

  task automatic test_short_windows();
    int ph;
    int k;
    int n;
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: set_pacing(0, 0);
        1: set_pacing(72, 0);
        2: set_pacing(0, 72);
        default: set_pacing(28, 28);
      endcase
      for (k = 0; k < 3; k++) begin
        write_length((k == 0) ? 9'd2 : 9'($urandom_range(3, 16)));
        for (n = 0; n < 50; n++)
          send_sample(next_sample());
      end
    end
  endtask

  task automatic test_long_windows();
    int n;
    set_pacing(0, 0);
    write_length(9'($urandom_range(257, 511)));
    for (n = 0; n < 300; n++)
      send_sample(next_sample());
    set_pacing(28, 28);
    write_length(9'd255);
    for (n = 0; n < 280; n++)
      send_sample(next_sample());
  endtask

  initial begin
    held           = 0;
    win_len        = 2;
    spike_total    = '0;
    last_sample    = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    test_directed_edges();
    test_short_windows();
    test_long_windows();
    wait_drained();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0)
      $display("tb_sliding_median_spike_detector OK");
    else
      $display("tb_sliding_median_spike_detector NOT OK");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+design
design/smsd_pkg.sv
design/smsd_cell.sv
design/sliding_median_spike_detector.sv
test/tb_sliding_median_spike_detector.sv
